FILE: src/text_stats_bom_classifier_assert.svh
// Assertion macros for the text statistics and byte order mark classifier.
`ifndef TEXT_STATS_BOM_CLASSIFIER_ASSERT_SVH
`define TEXT_STATS_BOM_CLASSIFIER_ASSERT_SVH
`ifndef SYNTH
`define TSB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TSB_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSB_ASSERT(name, clk, rst, prop, msg)
`define TSB_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: src/tsb_pkg.sv
// Types, constants and byte classification functions for the text statistics block.
`timescale 1ns / 1ps

package tsb_pkg;

   localparam int CountBits = 32;
   localparam int NumCnt    = 6;

   localparam logic [2:0] CNT_PRINT    = 3'd0;
   localparam logic [2:0] CNT_NONPRINT = 3'd1;
   localparam logic [2:0] CNT_NUL      = 3'd2;
   localparam logic [2:0] CNT_LF       = 3'd3;
   localparam logic [2:0] CNT_CR       = 3'd4;
   localparam logic [2:0] CNT_CRLF     = 3'd5;

   localparam logic [7:0] EofByte = 8'h1A;

   typedef logic [CountBits-1:0] count_type;
   typedef logic [NumCnt-1:0] bump_type;

   typedef enum logic [2:0] {
      BOM_NONE    = 3'd0,
      BOM_UTF8    = 3'd1,
      BOM_UTF16LE = 3'd2,
      BOM_UTF16BE = 3'd3,
      BOM_UTF32LE = 3'd4,
      BOM_UTF32BE = 3'd5
   } bom_type;

   typedef struct packed {
      bom_type    kind;
      logic [2:0] len;
   } mark_type;

   // Returns which counters one counted byte bumps.
   function automatic bump_type classify(input logic [7:0] c, input logic was_cr);
      bump_type b;
      b = '0;
      if ((c > 8'h1F && c < 8'h7F) || c > 8'h9F) begin
         b[CNT_PRINT] = 1'b1;
      end else begin
         case (c) inside
            8'h00: begin
               b[CNT_NUL]      = 1'b1;
               b[CNT_NONPRINT] = 1'b1;
            end
            8'h0A: begin
               b[CNT_LF]   = 1'b1;
               b[CNT_CRLF] = was_cr;
            end
            8'h0D: begin
               b[CNT_CR] = 1'b1;
            end
            8'h08, 8'h09, 8'h0B, 8'h0C, 8'h1B: begin
               b[CNT_PRINT] = 1'b1;
            end
            default: begin
               b[CNT_NONPRINT] = 1'b1;
            end
         endcase
      end
      return b;
   endfunction

   // Decides the byte order mark from the first n head bytes.
   function automatic mark_type detect_mark(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] n);
      mark_type m;
      m.kind = BOM_NONE;
      m.len  = 3'd0;
      if (n >= 3'd2) begin
         if (b0 == 8'h00) begin
            if (n >= 3'd4 && b1 == 8'h00 && b2 == 8'hFE && b3 == 8'hFF) begin
               m.kind = BOM_UTF32BE;
               m.len  = 3'd4;
            end
         end else if (b0 == 8'hEF) begin
            if (n >= 3'd3 && b1 == 8'hBB && b2 == 8'hBF) begin
               m.kind = BOM_UTF8;
               m.len  = 3'd3;
            end
         end else if (b0 == 8'hFE) begin
            if (b1 == 8'hFF) begin
               m.kind = BOM_UTF16BE;
               m.len  = 3'd2;
            end
         end else if (b0 == 8'hFF && b1 == 8'hFE) begin
            if (n >= 3'd4 && b2 == 8'h00 && b3 == 8'h00) begin
               m.kind = BOM_UTF32LE;
               m.len  = 3'd4;
            end else begin
               m.kind = BOM_UTF16LE;
               m.len  = 3'd2;
            end
         end
      end
      return m;
   endfunction

endpackage

FILE: src/text_stats_bom_classifier.sv
// Top level of the byte order mark detector and text statistics counter.
//
// A file enters as a stream of requests on req_*, one byte each, with
// req_last_byte set on its final byte; a file holds at least one byte.
// A byte can be accepted each clock while req_stall is low.
// The first four bytes are held to detect a UTF-8, UTF-16 or UTF-32 byte
// order mark; the held bytes are counted together once the mark is decided.
// The final request produces one result on rsp_*, valid in the cycle after
// that request is accepted: the mark kind, six saturating counters and the
// binary verdict. Other requests produce no result.
// The result register holds a finished result while rsp_stall is high;
// bytes of the next file are still accepted meanwhile, and req_stall rises
// only for a final byte that arrives while the previous result still waits.
// csr_wr_en writes the mark skip bit, which is sampled when the mark is
// decided; when it is set, the bytes of a detected mark are not counted.
// Synchronous reset clears the counters, the mark and rsp_valid, and clears
// the mark skip bit.
`timescale 1ns / 1ps
`include "text_stats_bom_classifier_assert.svh"

module text_stats_bom_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_bom_kind,
   output logic [31:0] rsp_printable_count,
   output logic [31:0] rsp_nonprintable_count,
   output logic [31:0] rsp_nul_count,
   output logic [31:0] rsp_lf_count,
   output logic [31:0] rsp_cr_count,
   output logic [31:0] rsp_crlf_count,
   output logic        rsp_looks_binary
);

   localparam int CntW = tsb_pkg::CountBits;
   localparam logic [CntW:0] MaxCnt = {1'b0, {CntW{1'b1}}};

   logic                skip_ff;
   logic [7:0]          window_ff [4];
   logic [2:0]          bytes_seen_ff, bytes_seen_in;
   logic                prev_cr_ff, prev_cr_in;
   tsb_pkg::count_type  cnt_ff [tsb_pkg::NumCnt];
   tsb_pkg::count_type  cnt_in [tsb_pkg::NumCnt];
   tsb_pkg::count_type  cnt_new [tsb_pkg::NumCnt];
   tsb_pkg::bom_type    bom_ff, bom_in, bom_now;
   logic                rsp_valid_ff, rsp_valid_in;
   tsb_pkg::bom_type    rsp_bom_ff;
   tsb_pkg::count_type  rsp_cnt_ff [tsb_pkg::NumCnt];
   logic                rsp_binary_ff, binary_now;

   logic                accept, load_rsp, deciding, eof;
   logic [2:0]          n_held, start_idx, stop_idx;
   logic [7:0]          head [4];
   logic [7:0]          slot_byte [4];
   logic [3:0]          slot_en;
   tsb_pkg::mark_type   mark;
   logic [2:0]          inc [tsb_pkg::NumCnt];
   logic [CntW:0]       sum [tsb_pkg::NumCnt];

   assign req_stall = rsp_valid_ff & rsp_stall & req_last_byte;
   assign accept    = req_valid & ~req_stall;
   assign load_rsp  = accept & req_last_byte;

   always_comb begin
      tsb_pkg::bump_type bumps;
      logic              cr_chain;

      n_held   = bytes_seen_ff + 3'd1;
      deciding = ~bytes_seen_ff[2] & ((n_held == 3'd4) | req_last_byte);
      eof      = req_last_byte & (req_data_byte == tsb_pkg::EofByte);

      for (int i = 0; i < 4; i++) begin
         head[i] = (2'(i) == bytes_seen_ff[1:0]) ? req_data_byte : window_ff[i];
      end
      mark = tsb_pkg::detect_mark(head[0], head[1], head[2], head[3], n_held);

      start_idx = skip_ff ? mark.len : 3'd0;
      stop_idx  = eof ? bytes_seen_ff : n_held;

      for (int s = 0; s < 4; s++) begin
         slot_byte[s] = head[s];
         slot_en[s]   = deciding && (3'(s) >= start_idx) && (3'(s) < stop_idx);
      end
      if (bytes_seen_ff[2]) begin
         slot_byte[0] = req_data_byte;
         slot_en      = {3'b000, ~eof};
      end

      for (int k = 0; k < tsb_pkg::NumCnt; k++) begin
         inc[k] = 3'd0;
      end
      cr_chain = prev_cr_ff;
      for (int s = 0; s < 4; s++) begin
         bumps = slot_en[s] ? tsb_pkg::classify(slot_byte[s], cr_chain) : '0;
         if (slot_en[s]) begin
            cr_chain = bumps[tsb_pkg::CNT_CR];
         end
         for (int k = 0; k < tsb_pkg::NumCnt; k++) begin
            inc[k] = inc[k] + 3'(bumps[k]);
         end
      end

      for (int k = 0; k < tsb_pkg::NumCnt; k++) begin
         sum[k]     = (CntW+1)'(cnt_ff[k]) + (CntW+1)'(inc[k]);
         cnt_new[k] = (sum[k] > MaxCnt) ? cnt_ff[k] | {CntW{1'b1}} : sum[k][CntW-1:0];
      end

      bom_now    = deciding ? mark.kind : bom_ff;
      binary_now = (|cnt_new[tsb_pkg::CNT_NUL])
                   || ((cnt_new[tsb_pkg::CNT_PRINT] >> 7) < cnt_new[tsb_pkg::CNT_NONPRINT]);

      bytes_seen_in = bytes_seen_ff;
      prev_cr_in    = prev_cr_ff;
      bom_in        = bom_ff;
      cnt_in        = cnt_ff;
      if (accept) begin
         if (req_last_byte) begin
            bytes_seen_in = 3'd0;
            prev_cr_in    = 1'b0;
            bom_in        = tsb_pkg::BOM_NONE;
            for (int k = 0; k < tsb_pkg::NumCnt; k++) begin
               cnt_in[k] = '0;
            end
         end else begin
            bytes_seen_in = (deciding || bytes_seen_ff[2]) ? 3'd4 : n_held;
            prev_cr_in    = cr_chain;
            bom_in        = bom_now;
            cnt_in        = cnt_new;
         end
      end

      rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff       <= 1'b0;
         bytes_seen_ff <= 3'd0;
         prev_cr_ff    <= 1'b0;
         bom_ff        <= tsb_pkg::BOM_NONE;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < tsb_pkg::NumCnt; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            skip_ff <= csr_wr_data;
         end
         bytes_seen_ff <= bytes_seen_in;
         prev_cr_ff    <= prev_cr_in;
         bom_ff        <= bom_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !bytes_seen_ff[2]) begin
         window_ff[bytes_seen_ff[1:0]] <= req_data_byte;
      end
      if (load_rsp) begin
         rsp_bom_ff    <= bom_now;
         rsp_cnt_ff    <= cnt_new;
         rsp_binary_ff <= binary_now;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_bom_kind           = rsp_bom_ff;
   assign rsp_printable_count    = 32'(rsp_cnt_ff[tsb_pkg::CNT_PRINT]);
   assign rsp_nonprintable_count = 32'(rsp_cnt_ff[tsb_pkg::CNT_NONPRINT]);
   assign rsp_nul_count          = 32'(rsp_cnt_ff[tsb_pkg::CNT_NUL]);
   assign rsp_lf_count           = 32'(rsp_cnt_ff[tsb_pkg::CNT_LF]);
   assign rsp_cr_count           = 32'(rsp_cnt_ff[tsb_pkg::CNT_CR]);
   assign rsp_crlf_count         = 32'(rsp_cnt_ff[tsb_pkg::CNT_CRLF]);
   assign rsp_looks_binary       = rsp_binary_ff;

   `TSB_ASSERT(a_last_gives_rsp, clock, reset,
               (req_valid && !req_stall && req_last_byte)
               |=> (rsp_valid_ff && bytes_seen_ff == 3'd0),
               "final request did not produce a result and clear the stream")
   `TSB_ASSERT(a_quiet_before_mark, clock, reset,
               (bytes_seen_ff != 3'd4) |-> (bom_ff == tsb_pkg::BOM_NONE
                  && cnt_ff[tsb_pkg::CNT_PRINT] == '0
                  && cnt_ff[tsb_pkg::CNT_NONPRINT] == '0
                  && cnt_ff[tsb_pkg::CNT_CR] == '0),
               "bytes counted before the mark was decided")
   `TSB_ASSERT(a_crlf_bounded, clock, reset,
               (cnt_ff[tsb_pkg::CNT_CRLF] <= cnt_ff[tsb_pkg::CNT_LF]
                && cnt_ff[tsb_pkg::CNT_CRLF] <= cnt_ff[tsb_pkg::CNT_CR]),
               "pair counter exceeds line feed or carriage return counter")
   `TSB_ASSERT_ALWAYS(a_stall_needs_rsp, clock, req_stall |-> rsp_valid_ff,
                      "request stalled with no result waiting")

endmodule
